[hw/rtl/sorted_double_ended_queue_unit_defines.svh]
// assertion macros for the sorted queue unit
`ifndef SORTED_DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH
`define SORTED_DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define SDEQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SDEQ_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SDEQ_ASSERT(label, clk, rst, prop, msg)
`define SDEQ_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

[hw/rtl/sdeq_pkg.sv]
package sdeq_pkg;

   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;

   typedef enum logic [1:0] {
      REQ_INS_FRONT = 2'd0,
      REQ_INS_BACK  = 2'd1,
      REQ_REM_MAX   = 2'd2,
      REQ_REM_MIN   = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_SHIFT_DOWN
   } cell_op_type;

   typedef struct packed {
      cell_op_type         op;
      logic [DATA_W-1:0]   new_value;
   } cell_ctl_type;

   // signed greater-than on two's complement patterns
   function automatic logic sgt(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
      return $signed(a) > $signed(b);
   endfunction

endpackage

[hw/rtl/sdeq_cell.sv]
module sdeq_cell (
   input  logic                         clock,
   input  sdeq_pkg::cell_ctl_type       ctl,
   input  logic                         valid,
   input  logic                         left_gt,
   input  logic [sdeq_pkg::DATA_W-1:0]  left_value,
   input  logic [sdeq_pkg::DATA_W-1:0]  right_value,
   output logic                         gt,
   output logic [sdeq_pkg::DATA_W-1:0]  value
);
   import sdeq_pkg::*;

   logic [DATA_W-1:0] entry_ff;
   logic [DATA_W-1:0] entry_in;

   // empty cells count as greater so the insert point lands on the fill edge
   assign gt    = !valid || sgt(entry_ff, ctl.new_value);
   assign value = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      unique case (ctl.op)
         CELL_HOLD: begin
            entry_in = entry_ff;
         end
         CELL_INSERT: begin
            if (left_gt) begin
               entry_in = left_value;
            end else if (gt) begin
               entry_in = ctl.new_value;
            end
         end
         CELL_SHIFT_DOWN: begin
            entry_in = right_value;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

[hw/rtl/sorted_double_ended_queue_unit.sv]
// sorted double-ended queue: a row of compare-and-shift cells, one value each
// result: registered strobe, raised in the cycle after the accepted beat
// throughput: one beat per cycle, busy stays low; every cell compares and shifts at once
// reset: synchronous, clears the entry count and the result strobe, cell contents undefined
// the receiver cannot stall: each result is shown for exactly one cycle
`include "sorted_double_ended_queue_unit_defines.svh"

module sorted_double_ended_queue_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_type,
   input  logic signed [31:0]           req_value,
   output logic                         rsp_valid,
   output logic [1:0]                   rsp_status,
   output logic signed [31:0]           rsp_removed_value,
   output logic [4:0]                   rsp_entry_count
);
   import sdeq_pkg::*;

   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   status_type          rsp_status_ff;
   status_type          rsp_status_in;
   logic [DATA_W-1:0]   rsp_removed_ff;
   logic [DATA_W-1:0]   rsp_removed_in;

   logic                accept;
   req_kind_type        kind;
   cell_ctl_type        ctl;
   logic [CAPACITY-1:0] valid;
   logic [CAPACITY-1:0] gt;
   logic [DATA_W-1:0]   cell_value [CAPACITY];
   logic [DATA_W-1:0]   last_sel   [CAPACITY];
   logic [DATA_W-1:0]   largest;
   logic                full;
   logic                empty;
   logic [CNT_W+4:0]    count_ext;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign kind   = req_kind_type'(req_type);
   assign full   = (count_ff == CNT_W'(CAPACITY));
   assign empty  = (count_ff == '0);

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic              lgt;
      logic [DATA_W-1:0] lval;
      logic [DATA_W-1:0] rval;

      assign valid[i] = (CNT_W'(i) < count_ff);

      if (i == 0) begin : g_first
         assign lgt  = 1'b0;
         assign lval = ctl.new_value;
      end else begin : g_mid
         assign lgt  = gt[i-1];
         assign lval = cell_value[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign rval        = cell_value[i];
         assign last_sel[i] = valid[i] ? cell_value[i] : '0;
      end else begin : g_inner
         assign rval        = cell_value[i+1];
         assign last_sel[i] = (valid[i] && !valid[i+1]) ? cell_value[i] : '0;
      end

      sdeq_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .valid       (valid[i]),
         .left_gt     (lgt),
         .left_value  (lval),
         .right_value (rval),
         .gt          (gt[i]),
         .value       (cell_value[i])
      );
   end

   always_comb begin
      largest = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         largest = largest | last_sel[i];
      end
   end

   always_comb begin
      ctl.op         = CELL_HOLD;
      ctl.new_value  = req_value;
      count_in       = count_ff;
      rsp_valid_in   = accept;
      rsp_status_in  = ST_DONE;
      rsp_removed_in = '0;
      if (accept) begin
         unique case (kind)
            REQ_INS_FRONT, REQ_INS_BACK: begin
               if (full) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  ctl.op   = CELL_INSERT;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            REQ_REM_MAX: begin
               if (empty) begin
                  rsp_status_in = ST_EMPTY;
               end else begin
                  rsp_removed_in = largest;
                  count_in       = count_ff - CNT_W'(1);
               end
            end
            REQ_REM_MIN: begin
               if (empty) begin
                  rsp_status_in = ST_EMPTY;
               end else begin
                  ctl.op         = CELL_SHIFT_DOWN;
                  rsp_removed_in = cell_value[0];
                  count_in       = count_ff - CNT_W'(1);
               end
            end
            default: begin
               rsp_status_in = ST_DONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff  <= rsp_status_in;
      rsp_removed_ff <= rsp_removed_in;
   end

   assign count_ext         = {5'b0, count_ff};
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_entry_count   = count_ext[4:0];

   `SDEQ_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(CAPACITY), "count over capacity")
   `SDEQ_ASSERT(a_one_result, clock, reset, start |=> rsp_valid, "accepted beat gave no result")
   `SDEQ_ASSERT(a_full_count, clock, reset, (rsp_valid && rsp_status == ST_FULL) |-> (count_ff == CNT_W'(CAPACITY)), "full status with room left")
   `SDEQ_ASSERT(a_empty_count, clock, reset, (rsp_valid && rsp_status == ST_EMPTY) |-> (count_ff == '0) && (rsp_removed_value == '0), "empty status with entries")
   `SDEQ_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid, "result strobe after reset")

endmodule
